// File: rtl/core/bdq_pkg.sv
// Shared types and codes for the bounded deque core.
// No dependencies; compiled before every other file of the block.
package bdq_pkg;

   localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
   localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
   localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
   localparam logic [2:0] FUNC_RESIZE     = 3'd4;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [4:0]         entry_count;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
      logic               is_empty;
      logic [1:0]         status;
   } rsp_payload_type;

endpackage

// File: rtl/core/bdq_channels.sv
// Valid/ready channel interfaces for the deque request and response beats.
// No dependencies.
interface bdq_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         func;
   logic signed [31:0] value;
   logic [4:0]         new_size;

   modport source (output valid, output func, output value, output new_size, input ready);
   modport sink (input valid, input func, input value, input new_size, output ready);
endinterface

interface bdq_rsp_if;
   logic               valid;
   logic               ready;
   logic [4:0]         entry_count;
   logic signed [31:0] front_value;
   logic signed [31:0] back_value;
   logic               is_empty;
   logic [1:0]         status;

   modport source (output valid, output entry_count, output front_value,
                   output back_value, output is_empty, output status, input ready);
   modport sink (input valid, input entry_count, input front_value,
                 input back_value, input is_empty, input status, output ready);
endinterface

// File: rtl/core/bounded_deque_with_resize_core.sv
// Top level of the bounded deque: entry RAM, sequencer and response register.
// Depends on bdq_pkg, bdq_channels, bdq_ram, bdq_engine and bdq_out_reg.
//
//   channel    dir  beat
//   req_chan   in   func, value, new_size
//   rsp_chan   out  entry_count, front_value, back_value, is_empty, status
//
// Push, refused op, no-op resize, pop or shrink that empties: result registered straight from ST_IDLE; back-to-back
// while the response drains.
// Pop and shrink that leave entries pass through ST_READ for the registered RAM read of the new end.
// Growing resize appends one entry at a time in ST_FILL (single RAM write port).
// Synchronous reset empties the deque; entry RAM contents are not cleared.
// A stalled response holds one beat; a further finished beat waits inside.
module bounded_deque_with_resize_core #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   bdq_req_if.sink   req_chan,
   bdq_rsp_if.source rsp_chan
);
   import bdq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);

   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   logic [VALUE_BITS-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic [VALUE_BITS-1:0] ram_rd_data;
   logic                  res_valid;
   logic                  res_take;
   rsp_payload_type       res;

   bdq_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bdq_engine #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .res_valid   (res_valid),
      .res         (res),
      .res_take    (res_take)
   );

   bdq_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .res_take  (res_take),
      .rsp_chan  (rsp_chan)
   );

endmodule

// File: rtl/core/bdq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/bdq_engine.sv
// Deque sequencer: ring pointers, count, cached front/back values, fill loop.
// Depends on bdq_pkg and bdq_channels; drives the entry RAM ports.
module bdq_engine #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   bdq_req_if.sink                     req_chan,
   output logic                        ram_wr_en,
   output logic [$clog2(CAPACITY)-1:0] ram_wr_addr,
   output logic [VALUE_BITS-1:0]       ram_wr_data,
   output logic                        ram_rd_en,
   output logic [$clog2(CAPACITY)-1:0] ram_rd_addr,
   input  logic [VALUE_BITS-1:0]       ram_rd_data,
   output logic                        res_valid,
   output bdq_pkg::rsp_payload_type    res,
   input  logic                        res_take
);
   import bdq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
   localparam logic [CNT_W:0]   CAP_WIDE = (CNT_W + 1)'(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_FILL = 3'b100
   } fsm_state_type;

   fsm_state_type           state_ff, state_in;
   logic [IDX_W-1:0]        first_ff, first_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        target_ff, target_in;
   logic [VALUE_BITS-1:0]   front_ff, front_in;
   logic [VALUE_BITS-1:0]   back_ff, back_in;
   logic [VALUE_BITS-1:0]   fill_ff, fill_in;
   logic [1:0]              status_ff, status_in;
   logic                    pending_ff, pending_in;
   logic                    read_front_ff, read_front_in;

   logic                    accept;
   logic                    is_full;
   logic                    is_none;
   logic                    size_sat;
   logic [CNT_W-1:0]        size_tgt;
   logic [IDX_W-1:0]        prev_first;
   logic [VALUE_BITS-1:0]   in_value;

   function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] first,
                                                 input logic [CNT_W-1:0] offset);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(first) + (CNT_W + 1)'(offset);
      if (sum >= CAP_WIDE) begin
         sum = sum - CAP_WIDE;
      end
      return IDX_W'(sum);
   endfunction

   assign accept     = req_chan.valid && req_chan.ready;
   assign is_full    = (count_ff == CAP_CNT);
   assign is_none    = (count_ff == '0);
   assign size_sat   = (32'(req_chan.new_size) > 32'(CAPACITY));
   assign size_tgt   = size_sat ? CAP_CNT : CNT_W'(req_chan.new_size);
   assign prev_first = (first_ff == '0) ? LAST_IDX : first_ff - 1'b1;
   assign in_value   = VALUE_BITS'($unsigned(req_chan.value));

   assign req_chan.ready = (state_ff == ST_IDLE) && (!pending_ff || res_take);

   always_comb begin
      state_in      = state_ff;
      first_in      = first_ff;
      count_in      = count_ff;
      target_in     = target_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      fill_in       = fill_ff;
      status_in     = status_ff;
      pending_in    = pending_ff && !res_take;
      read_front_in = read_front_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = ring_pos(first_ff, count_ff);
      ram_wr_data   = in_value;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = ring_pos(first_ff, CNT_W'(1));

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in = STATUS_DONE;
               case (req_chan.func)
                  FUNC_PUSH_FRONT: begin
                     pending_in = 1'b1;
                     if (is_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = prev_first;
                        first_in    = prev_first;
                        count_in    = count_ff + 1'b1;
                        front_in    = in_value;
                        if (is_none) begin
                           back_in = in_value;
                        end
                     end
                  end
                  FUNC_PUSH_BACK: begin
                     pending_in = 1'b1;
                     if (is_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + 1'b1;
                        back_in   = in_value;
                        if (is_none) begin
                           front_in = in_value;
                        end
                     end
                  end
                  FUNC_POP_FRONT: begin
                     if (is_none) begin
                        status_in  = STATUS_EMPTY;
                        pending_in = 1'b1;
                     end else begin
                        first_in = ring_pos(first_ff, CNT_W'(1));
                        count_in = count_ff - 1'b1;
                        if (count_ff == CNT_W'(1)) begin
                           pending_in = 1'b1;
                        end else begin
                           ram_rd_en     = 1'b1;
                           read_front_in = 1'b1;
                           state_in      = ST_READ;
                        end
                     end
                  end
                  FUNC_POP_BACK: begin
                     if (is_none) begin
                        status_in  = STATUS_EMPTY;
                        pending_in = 1'b1;
                     end else begin
                        count_in = count_ff - 1'b1;
                        if (count_ff == CNT_W'(1)) begin
                           pending_in = 1'b1;
                        end else begin
                           ram_rd_en     = 1'b1;
                           ram_rd_addr   = ring_pos(first_ff, count_ff - CNT_W'(2));
                           read_front_in = 1'b0;
                           state_in      = ST_READ;
                        end
                     end
                  end
                  FUNC_RESIZE: begin
                     status_in = size_sat ? STATUS_FULL : STATUS_DONE;
                     if (size_tgt > count_ff) begin
                        target_in = size_tgt;
                        fill_in   = in_value;
                        state_in  = ST_FILL;
                     end else if (size_tgt < count_ff) begin
                        count_in = size_tgt;
                        if (size_tgt == '0) begin
                           pending_in = 1'b1;
                        end else begin
                           ram_rd_en     = 1'b1;
                           ram_rd_addr   = ring_pos(first_ff, size_tgt - 1'b1);
                           read_front_in = 1'b0;
                           state_in      = ST_READ;
                        end
                     end else begin
                        pending_in = 1'b1;
                     end
                  end
                  default: begin
                     pending_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (read_front_ff) begin
               front_in = ram_rd_data;
            end else begin
               back_in = ram_rd_data;
            end
            pending_in = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = fill_ff;
            count_in    = count_ff + 1'b1;
            back_in     = fill_ff;
            if (is_none) begin
               front_in = fill_ff;
            end
            if (count_ff + 1'b1 == target_ff) begin
               pending_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         first_ff   <= '0;
         count_ff   <= '0;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         first_ff   <= first_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff     <= target_in;
      front_ff      <= front_in;
      back_ff       <= back_in;
      fill_ff       <= fill_in;
      status_ff     <= status_in;
      read_front_ff <= read_front_in;
   end

   assign res_valid       = pending_ff;
   assign res.entry_count = 5'(count_ff);
   assign res.front_value = is_none ? '0 : 32'(front_ff);
   assign res.back_value  = is_none ? '0 : 32'(back_ff);
   assign res.is_empty    = is_none;
   assign res.status      = status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   a_read_not_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !pending_ff)
      else $error("result pending during RAM read");

   a_fill_below_target: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (count_ff < target_ff))
      else $error("fill loop past target");

   a_take_from_pending: assert property (@(posedge clock) disable iff (reset)
      res_take |-> pending_ff)
      else $error("result taken with none pending");

endmodule

// File: rtl/core/bdq_out_reg.sv
// Response output register: holds one result beat until the sink takes it.
// Depends on bdq_pkg and bdq_channels.
module bdq_out_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     res_valid,
   input  bdq_pkg::rsp_payload_type res,
   output logic                     res_take,
   bdq_rsp_if.source                rsp_chan
);
   import bdq_pkg::*;

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff, data_in;

   assign res_take = res_valid && (!valid_ff || rsp_chan.ready);

   always_comb begin
      valid_in = valid_ff && !rsp_chan.ready;
      data_in  = data_ff;
      if (res_take) begin
         valid_in = 1'b1;
         data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.entry_count = data_ff.entry_count;
   assign rsp_chan.front_value = data_ff.front_value;
   assign rsp_chan.back_value  = data_ff.back_value;
   assign rsp_chan.is_empty    = data_ff.is_empty;
   assign rsp_chan.status      = data_ff.status;

endmodule

// File: verif/bounded_deque_with_resize_core_tb.sv
// Self-checking bench for bounded_deque_with_resize_core: directed table, then random op mix.
// Depends on bdq_pkg and bdq_channels (bdq_req_if, bdq_rsp_if) from rtl/core.
module bounded_deque_with_resize_core_tb;
   import bdq_pkg::*;

   localparam int DEPTH = 16;
   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 12;
   localparam int ITEMS_PER_PHASE = 288;
   localparam int SETTLE_CYCLES = 48;
   localparam int HOLD_CYCLES = 96;
   localparam int TIMEOUT_UNITS = 12 * 600000;
   localparam int N_DIRECTED = 24;

   localparam logic [2:0] FUNC_SPARE_LO  = 3'd5;
   localparam logic [2:0] FUNC_SPARE_MID = 3'd6;
   localparam logic [2:0] FUNC_SPARE_HI  = 3'd7;

   localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] value;
      logic [4:0]         new_size;
      logic               pinned;
      rsp_payload_type    rsp;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bdq_req_if req_chan();
   bdq_rsp_if rsp_chan();

   bounded_deque_with_resize_core #(
      .CAPACITY   (DEPTH),
      .VALUE_BITS (32)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // shadow deque
   logic signed [31:0] shadow_ring [DEPTH];
   logic [3:0]         shadow_head = '0;
   logic [4:0]         shadow_count = '0;

   rsp_payload_type rsp_queue [$];
   logic            req_pinned = 1'b0;
   rsp_payload_type req_pinned_rsp = '0;

   int mismatches = 0;
   int sender_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;

   directed_row_type directed_rows [N_DIRECTED];

   task automatic log_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
      mismatches++;
      $display("%0t %s: got %h want %h", $time, what, got, want);
   endtask

   task automatic predict_deque_rsp(input logic [2:0] func, input logic signed [31:0] value,
                                    input logic [4:0] new_size, output rsp_payload_type r);
      logic [4:0] target;
      logic [3:0] slot;
      target = new_size;
      r = '0;
      r.status = STATUS_DONE;
      case (func)
         FUNC_PUSH_FRONT: begin
            if (shadow_count >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               shadow_head = shadow_head - 4'd1;
               shadow_ring[shadow_head] = value;
               shadow_count = shadow_count + 5'd1;
            end
         end
         FUNC_PUSH_BACK: begin
            if (shadow_count >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               slot = shadow_head + shadow_count[3:0];
               shadow_ring[slot] = value;
               shadow_count = shadow_count + 5'd1;
            end
         end
         FUNC_POP_FRONT: begin
            if (shadow_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               shadow_head = shadow_head + 4'd1;
               shadow_count = shadow_count - 5'd1;
            end
         end
         FUNC_POP_BACK: begin
            if (shadow_count == 0) r.status = STATUS_EMPTY;
            else shadow_count = shadow_count - 5'd1;
         end
         FUNC_RESIZE: begin
            if (target > DEPTH) begin
               target = 5'(DEPTH);
               r.status = STATUS_FULL;
            end
            while (shadow_count < target) begin
               slot = shadow_head + shadow_count[3:0];
               shadow_ring[slot] = value;
               shadow_count = shadow_count + 5'd1;
            end
            if (shadow_count > target) shadow_count = target;
         end
         default: ;
      endcase
      r.entry_count = shadow_count;
      if (shadow_count == 0) begin
         r.is_empty = 1'b1;
      end else begin
         slot = shadow_head + shadow_count[3:0] - 4'd1;
         r.front_value = shadow_ring[shadow_head];
         r.back_value = shadow_ring[slot];
      end
   endtask

   // response check first: a beat leaving now belongs to an older request
   always @(posedge clock) begin
      rsp_payload_type want, got;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.entry_count = rsp_chan.entry_count;
            got.front_value = rsp_chan.front_value;
            got.back_value = rsp_chan.back_value;
            got.is_empty = rsp_chan.is_empty;
            got.status = rsp_chan.status;
            if (rsp_queue.size() == 0) begin
               log_mismatch("unexpected beat, entry_count", 32'(got.entry_count), '0);
            end else begin
               want = rsp_queue.pop_front();
               if (got.entry_count !== want.entry_count)
                  log_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
               if (got.front_value !== want.front_value)
                  log_mismatch("front_value", got.front_value, want.front_value);
               if (got.back_value !== want.back_value)
                  log_mismatch("back_value", got.back_value, want.back_value);
               if (got.is_empty !== want.is_empty)
                  log_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
               if (got.status !== want.status)
                  log_mismatch("status", 32'(got.status), 32'(want.status));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            predict_deque_rsp(req_chan.func, req_chan.value, req_chan.new_size, want);
            rsp_queue.push_back(req_pinned ? req_pinned_rsp : want);
         end
      end
   end

   // receiver: random stalls plus long hold-offs on request
   initial begin
      int hold_left;
      int hold_served;
      hold_left = 0;
      hold_served = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic offer_beat(input logic [2:0] func, input logic signed [31:0] value,
                             input logic [4:0] new_size, input logic pinned,
                             input rsp_payload_type pin_rsp);
      req_chan.valid <= 1'b1;
      req_chan.func <= func;
      req_chan.value <= value;
      req_chan.new_size <= new_size;
      req_pinned <= pinned;
      req_pinned_rsp <= pin_rsp;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // one edge first so the last accepted beat is already queued
   task automatic wait_drained();
      @(posedge clock);
      while (rsp_queue.size() != 0) @(posedge clock);
   endtask

   initial begin
      #(TIMEOUT_UNITS);
      $display("bounded_deque_with_resize_core: mismatch");
      $finish;
   end

   initial begin
      int idle_pcts [4];
      int stall_pcts [4];
      int pick;
      int lean;
      logic [2:0] op;
      logic signed [31:0] val;
      logic [4:0] size;

      idle_pcts = '{0, 65, 0, 26};
      stall_pcts = '{0, 0, 65, 26};
      directed_rows = '{
         '{FUNC_POP_FRONT,  32'sd0,       5'd0,  1'b1,
           '{5'd0,  32'sd0,       32'sd0,       1'b1, STATUS_EMPTY}},
         '{FUNC_POP_BACK,   32'sd0,       5'd0,  1'b1,
           '{5'd0,  32'sd0,       32'sd0,       1'b1, STATUS_EMPTY}},
         '{FUNC_SPARE_LO,   32'sd0,       5'd0,  1'b1,
           '{5'd0,  32'sd0,       32'sd0,       1'b1, STATUS_DONE}},
         '{FUNC_RESIZE,     32'sd0,       5'd0,  1'b1,
           '{5'd0,  32'sd0,       32'sd0,       1'b1, STATUS_DONE}},
         '{FUNC_PUSH_BACK,  VAL_MAX,      5'd0,  1'b1,
           '{5'd1,  VAL_MAX,      VAL_MAX,      1'b0, STATUS_DONE}},
         '{FUNC_PUSH_FRONT, VAL_MIN,      5'd0,  1'b1,
           '{5'd2,  VAL_MIN,      VAL_MAX,      1'b0, STATUS_DONE}},
         '{FUNC_RESIZE,     32'sd9,       5'd2,  1'b0, '0},
         '{FUNC_POP_BACK,   32'sd0,       5'd0,  1'b0, '0},
         '{FUNC_POP_FRONT,  32'sd0,       5'd0,  1'b1,
           '{5'd0,  32'sd0,       32'sd0,       1'b1, STATUS_DONE}},
         '{FUNC_RESIZE,     -32'sd1,      5'd16, 1'b1,
           '{5'd16, -32'sd1,      -32'sd1,      1'b0, STATUS_DONE}},
         '{FUNC_PUSH_FRONT, 32'sd5,       5'd0,  1'b1,
           '{5'd16, -32'sd1,      -32'sd1,      1'b0, STATUS_FULL}},
         '{FUNC_PUSH_BACK,  32'sd5,       5'd0,  1'b1,
           '{5'd16, -32'sd1,      -32'sd1,      1'b0, STATUS_FULL}},
         '{FUNC_RESIZE,     32'sd99,      5'd3,  1'b0, '0},
         '{FUNC_PUSH_FRONT, 32'sh5555_5555, 5'd0, 1'b0, '0},
         '{FUNC_PUSH_BACK,  32'shaaaa_aaaa, 5'd0, 1'b0, '0},
         '{FUNC_RESIZE,     32'sd7,       5'd31, 1'b1,
           '{5'd16, 32'sh5555_5555, 32'sd7,     1'b0, STATUS_FULL}},
         '{FUNC_RESIZE,     32'sd0,       5'd17, 1'b0, '0},
         '{FUNC_SPARE_MID,  VAL_MIN,      5'd31, 1'b0, '0},
         '{FUNC_RESIZE,     32'sd0,       5'd0,  1'b1,
           '{5'd0,  32'sd0,       32'sd0,       1'b1, STATUS_DONE}},
         '{FUNC_PUSH_FRONT, 32'sd1,       5'd0,  1'b0, '0},
         '{FUNC_POP_BACK,   32'sd0,       5'd0,  1'b0, '0},
         '{FUNC_SPARE_HI,   VAL_MAX,      5'd16, 1'b1,
           '{5'd0,  32'sd0,       32'sd0,       1'b1, STATUS_DONE}},
         '{FUNC_RESIZE,     VAL_MIN,      5'd1,  1'b0, '0},
         '{FUNC_PUSH_FRONT, 32'sd0,       5'd0,  1'b0, '0}
      };

      req_chan.valid <= 1'b0;
      req_chan.func <= FUNC_PUSH_BACK;
      req_chan.value <= '0;
      req_chan.new_size <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer_beat(directed_rows[i].func, directed_rows[i].value, directed_rows[i].new_size,
                    directed_rows[i].pinned, directed_rows[i].rsp);

      lean = 2;
      for (int phase = 0; phase < 4; phase++) begin
         req_chan.valid <= 1'b0;
         wait_drained();
         sender_idle_pct = idle_pcts[phase];
         rsp_stall_pct = stall_pcts[phase];
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ((phase == 0 && n == 100) || (phase == 2 && n == 150))
               hold_requests <= hold_requests + 1;
            // lean toward filling, draining or neither for a stretch of beats
            if (n % 32 == 0) lean = $urandom_range(2);
            pick = $urandom_range(99);
            if (pick < 4) begin
               op = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
            end else if (pick < 16) begin
               op = FUNC_RESIZE;
            end else if ($urandom_range(99) < (lean == 0 ? 75 : lean == 1 ? 25 : 50)) begin
               op = $urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
            end else begin
               op = $urandom_range(1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
            end
            if ($urandom_range(7) == 0) begin
               case ($urandom_range(3))
                  0: val = VAL_MAX;
                  1: val = VAL_MIN;
                  2: val = 32'sd0;
                  default: val = -32'sd1;
               endcase
            end else begin
               val = $urandom;
            end
            if ($urandom_range(9) == 0) size = 5'($urandom_range(17, 31));
            else size = 5'($urandom_range(0, DEPTH));
            offer_beat(op, val, size, 1'b0, '0);
         end
      end

      req_chan.valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && rsp_queue.size() == 0)
         $display("bounded_deque_with_resize_core: match");
      else
         $display("bounded_deque_with_resize_core: mismatch");
      $finish;
   end

endmodule
